// File: rtl/core/seqno_ordered_packet_queue_unit_macros.svh
// assertion macros for the sequence-ordered packet queue
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef SEQNO_ORDERED_PACKET_QUEUE_UNIT_MACROS_SVH
`define SEQNO_ORDERED_PACKET_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define SOPQ_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sopq same-cycle check failed");

// next-cycle implication
`define SOPQ_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sopq next-cycle check failed");

`endif

// File: rtl/core/sopq_pkg.sv
// shared types and constants of the sequence-ordered packet queue
// no dependencies
`timescale 1ns / 1ps

package sopq_pkg;

    localparam int HDL_W  = 16;
    localparam int BYT_W  = 16;
    localparam int TIME_W = 32;

    typedef enum logic [3:0] {
        CMD_PUSH_BACK    = 4'd0,
        CMD_PUSH_FRONT_U = 4'd1,
        CMD_ORDERED      = 4'd2,
        CMD_POP_FRONT    = 4'd3,
        CMD_POP_BACK     = 4'd4,
        CMD_PEEK_FRONT   = 4'd5,
        CMD_PEEK_BACK    = 4'd6,
        CMD_REMOVE_SEQ   = 4'd7,
        CMD_PEEK_SEQ     = 4'd8,
        CMD_POP_SENDABLE = 4'd9,
        CMD_DROP_TILL    = 4'd10,
        CMD_TOTAL_SIZE   = 4'd11,
        CMD_SIZE_AT      = 4'd12,
        CMD_SHRINK       = 4'd13,
        CMD_LENGTH       = 4'd14,
        CMD_TOUCH        = 4'd15
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_DUP  = 2'd2,
        STS_FULL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        COP_HOLD,
        COP_LOAD,
        COP_LEFT,
        COP_RIGHT,
        COP_SHRINK
    } t_cell_op;

    typedef enum logic [1:0] {
        MT_EQ,
        MT_GT,
        MT_SENDABLE,
        MT_DROP
    } t_match;

    typedef struct packed {
        logic   eval;
        t_match mode;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DSCAN,
        S_DREM
    } t_state;

endpackage

// File: rtl/core/sopq_cell.sv
// one queue slot: holds an entry, shifts to/from neighbors, keeps a match flag
// depends on sopq_pkg
`timescale 1ns / 1ps

module sopq_cell #(
    parameter int SEQ_BITS = 12
) (
    input  logic                            i_clk,
    input  sopq_pkg::t_cell_ctl             i_ctl,
    input  sopq_pkg::t_cell_op              i_op,
    input  logic signed [SEQ_BITS:0]        i_key,
    input  logic [sopq_pkg::BYT_W-1:0]      i_shrink,
    input  logic [sopq_pkg::HDL_W-1:0]      i_new_hdl,
    input  logic signed [SEQ_BITS:0]        i_new_seq,
    input  logic [sopq_pkg::BYT_W-1:0]      i_new_byt,
    input  logic [sopq_pkg::HDL_W-1:0]      i_lft_hdl,
    input  logic signed [SEQ_BITS:0]        i_lft_seq,
    input  logic [sopq_pkg::BYT_W-1:0]      i_lft_byt,
    input  logic [sopq_pkg::HDL_W-1:0]      i_rgt_hdl,
    input  logic signed [SEQ_BITS:0]        i_rgt_seq,
    input  logic [sopq_pkg::BYT_W-1:0]      i_rgt_byt,
    output logic [sopq_pkg::HDL_W-1:0]      o_hdl,
    output logic signed [SEQ_BITS:0]        o_seq,
    output logic [sopq_pkg::BYT_W-1:0]      o_byt,
    output logic                            o_flag
);

    logic [sopq_pkg::HDL_W-1:0] r_hdl, n_hdl;
    logic signed [SEQ_BITS:0]   r_seq, n_seq;
    logic [sopq_pkg::BYT_W-1:0] r_byt, n_byt;
    logic                       r_flag, n_flag;

    // slot update
    always_comb begin
        n_hdl = r_hdl;
        n_seq = r_seq;
        n_byt = r_byt;
        unique case (i_op)
            sopq_pkg::COP_HOLD: ;
            sopq_pkg::COP_LOAD: begin
                n_hdl = i_new_hdl;
                n_seq = i_new_seq;
                n_byt = i_new_byt;
            end
            sopq_pkg::COP_LEFT: begin
                n_hdl = i_lft_hdl;
                n_seq = i_lft_seq;
                n_byt = i_lft_byt;
            end
            sopq_pkg::COP_RIGHT: begin
                n_hdl = i_rgt_hdl;
                n_seq = i_rgt_seq;
                n_byt = i_rgt_byt;
            end
            sopq_pkg::COP_SHRINK: n_byt = r_byt - i_shrink;
            default: ;
        endcase
    end

    // key compare, captured when a word is taken
    always_comb begin
        n_flag = r_flag;
        if (i_ctl.eval) begin
            unique case (i_ctl.mode)
                sopq_pkg::MT_EQ:       n_flag = (r_seq == i_key);
                sopq_pkg::MT_GT:       n_flag = (r_seq > i_key);
                sopq_pkg::MT_SENDABLE: n_flag = !r_seq[SEQ_BITS];
                sopq_pkg::MT_DROP:     n_flag = !r_seq[SEQ_BITS] && (r_seq < i_key);
                default:               n_flag = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdl  <= n_hdl;
        r_seq  <= n_seq;
        r_byt  <= n_byt;
        r_flag <= n_flag;
    end

    assign o_hdl  = r_hdl;
    assign o_seq  = r_seq;
    assign o_byt  = r_byt;
    assign o_flag = r_flag;

endmodule

// File: rtl/core/seqno_ordered_packet_queue_unit.sv
// each accepted word is captured, executed in S_EXEC and its result registered;
// drop_till instead scans its matches one by one in S_DSCAN, then removes them in S_DREM
// with one result per removal, or gives a single miss result when nothing matches
// a new word is taken only in S_IDLE; results wait while the output register is held
// synchronous active-low reset empties the queue and clears the served time;
// slot contents are not cleared and are never read past the fill count
`timescale 1ns / 1ps
`include "seqno_ordered_packet_queue_unit_macros.svh"

module seqno_ordered_packet_queue_unit #(
    parameter int DEPTH    = 64,
    parameter int SEQ_BITS = 12
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_in_valid,
    output logic                                         o_in_ready,
    input  logic [3:0]                                   i_cmd,
    input  logic signed [SEQ_BITS:0]                     i_key_seq,
    input  logic [sopq_pkg::HDL_W-1:0]                   i_pkt_handle,
    input  logic [sopq_pkg::BYT_W-1:0]                   i_pkt_bytes,
    input  logic [$clog2(DEPTH+1)-1:0]                   i_position,
    input  logic [sopq_pkg::BYT_W-1:0]                   i_shrink_bytes,
    input  logic [sopq_pkg::TIME_W-1:0]                  i_now_time,
    output logic                                         o_out_valid,
    input  logic                                         i_out_ready,
    output logic [1:0]                                   o_status,
    output logic [sopq_pkg::HDL_W-1:0]                   o_out_handle,
    output logic signed [SEQ_BITS:0]                     o_out_seq,
    output logic [sopq_pkg::BYT_W-1:0]                   o_out_bytes,
    output logic [sopq_pkg::BYT_W+$clog2(DEPTH)-1:0]     o_total_bytes,
    output logic [$clog2(DEPTH+1)-1:0]                   o_queue_length,
    output logic [sopq_pkg::TIME_W-1:0]                  o_served_time,
    output logic                                         o_last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int TOT_W = sopq_pkg::BYT_W + $clog2(DEPTH);
    localparam int LVL   = $clog2(DEPTH);
    localparam int HW    = sopq_pkg::HDL_W;
    localparam int BW    = sopq_pkg::BYT_W;

    // control registers
    sopq_pkg::t_state           r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [TOT_W-1:0]           r_total, n_total;
    logic [sopq_pkg::TIME_W-1:0] r_served, n_served;
    logic [DEPTH-1:0]           r_dscan, n_dscan;
    logic [DEPTH-1:0]           r_drem, n_drem;
    logic [TOT_W-1:0]           r_dsum, n_dsum;
    logic [CNT_W-1:0]           r_dcnt, n_dcnt;

    // captured word
    sopq_pkg::t_cmd             r_cmd;
    logic signed [SEQ_BITS:0]   r_key;
    logic [HW-1:0]              r_hdl;
    logic [BW-1:0]              r_byt;
    logic [CNT_W-1:0]           r_pos;
    logic [BW-1:0]              r_shr;
    logic [sopq_pkg::TIME_W-1:0] r_now;

    // cell row
    logic [HW-1:0]              w_hdl [DEPTH];
    logic signed [SEQ_BITS:0]   w_seq [DEPTH];
    logic [BW-1:0]              w_byt [DEPTH];
    logic [DEPTH-1:0]           w_flag;
    sopq_pkg::t_cell_op         w_op  [DEPTH];
    sopq_pkg::t_cell_ctl        w_ctl;

    logic                       w_accept;
    logic                       w_ofree;
    logic [DEPTH-1:0]           w_occ;
    logic [DEPTH-1:0]           w_fl;
    logic [DEPTH-1:0]           w_src;
    logic [DEPTH-1:0]           w_sfirst;
    logic                       w_found;
    logic [CNT_W-1:0]           w_idx;
    logic                       w_use_search;
    logic [DEPTH-1:0]           w_idx_oh;
    logic [DEPTH-1:0]           w_tgt;
    logic [DEPTH-1:0]           w_ge;
    logic [HW-1:0]              w_rd_hdl;
    logic signed [SEQ_BITS:0]   w_rd_seq;
    logic [BW-1:0]              w_rd_byt;
    logic                       w_empty;
    logic                       w_full;
    logic                       w_ins;
    logic                       w_rem;
    logic                       w_shk;
    logic                       w_emit;
    logic [1:0]                 w_e_sts;
    logic [HW-1:0]              w_e_hdl;
    logic signed [SEQ_BITS:0]   w_e_seq;
    logic [BW-1:0]              w_e_byt;
    logic                       w_e_last;

    // inclusive prefix or, log-depth
    function automatic logic [DEPTH-1:0] f_prefix(input logic [DEPTH-1:0] v);
        logic [DEPTH-1:0] p;
        p = v;
        for (int s = 0; s < LVL; s++) begin
            p = p | (p << (1 << s));
        end
        return p;
    endfunction

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == sopq_pkg::S_IDLE);
    assign w_ofree    = !o_out_valid || i_out_ready;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CNT_W'(DEPTH));

    // compare mode broadcast at accept
    always_comb begin
        w_ctl.eval = w_accept;
        unique case (sopq_pkg::t_cmd'(i_cmd))
            sopq_pkg::CMD_ORDERED:      w_ctl.mode = sopq_pkg::MT_GT;
            sopq_pkg::CMD_POP_SENDABLE: w_ctl.mode = sopq_pkg::MT_SENDABLE;
            sopq_pkg::CMD_DROP_TILL:    w_ctl.mode = sopq_pkg::MT_DROP;
            default:                    w_ctl.mode = sopq_pkg::MT_EQ;
        endcase
    end

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [HW-1:0]            w_l_hdl, w_r_hdl;
        logic signed [SEQ_BITS:0] w_l_seq, w_r_seq;
        logic [BW-1:0]            w_l_byt, w_r_byt;

        if (g == 0) begin : g_lft_end
            assign w_l_hdl = r_hdl;
            assign w_l_seq = r_key;
            assign w_l_byt = r_byt;
        end else begin : g_lft
            assign w_l_hdl = w_hdl[g-1];
            assign w_l_seq = w_seq[g-1];
            assign w_l_byt = w_byt[g-1];
        end
        if (g == DEPTH - 1) begin : g_rgt_end
            assign w_r_hdl = w_hdl[g];
            assign w_r_seq = w_seq[g];
            assign w_r_byt = w_byt[g];
        end else begin : g_rgt
            assign w_r_hdl = w_hdl[g+1];
            assign w_r_seq = w_seq[g+1];
            assign w_r_byt = w_byt[g+1];
        end

        sopq_cell #(
            .SEQ_BITS (SEQ_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_op      (w_op[g]),
            .i_key     (i_key_seq),
            .i_shrink  (r_shr),
            .i_new_hdl (r_hdl),
            .i_new_seq (r_key),
            .i_new_byt (r_byt),
            .i_lft_hdl (w_l_hdl),
            .i_lft_seq (w_l_seq),
            .i_lft_byt (w_l_byt),
            .i_rgt_hdl (w_r_hdl),
            .i_rgt_seq (w_r_seq),
            .i_rgt_byt (w_r_byt),
            .o_hdl     (w_hdl[g]),
            .o_seq     (w_seq[g]),
            .o_byt     (w_byt[g]),
            .o_flag    (w_flag[g])
        );
    end

    // occupancy and index decode
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_occ[i]    = (CNT_W'(i) < r_count);
            w_idx_oh[i] = (CNT_W'(i) == w_idx);
        end
    end

    assign w_fl = w_flag & w_occ;

    // first set bit of the active search vector
    always_comb begin
        case (r_state)
            sopq_pkg::S_DSCAN: w_src = r_dscan;
            sopq_pkg::S_DREM:  w_src = r_drem;
            default:           w_src = w_fl;
        endcase
        w_sfirst = w_src & ~(f_prefix(w_src) << 1);
        w_found  = |w_src;
    end

    // target slot selection
    always_comb begin
        w_idx        = '0;
        w_use_search = 1'b0;
        case (r_cmd)
            sopq_pkg::CMD_PUSH_BACK:    w_idx = r_count;
            sopq_pkg::CMD_ORDERED: begin
                w_idx        = r_count;
                w_use_search = w_found;
            end
            sopq_pkg::CMD_POP_BACK,
            sopq_pkg::CMD_PEEK_BACK:    w_idx = r_count - CNT_W'(1);
            sopq_pkg::CMD_SIZE_AT:      w_idx = r_pos - CNT_W'(1);
            sopq_pkg::CMD_REMOVE_SEQ,
            sopq_pkg::CMD_PEEK_SEQ,
            sopq_pkg::CMD_POP_SENDABLE: w_use_search = 1'b1;
            default:                    w_idx = '0;
        endcase
        if (r_state != sopq_pkg::S_EXEC || w_use_search) begin
            w_tgt = w_sfirst;
        end else begin
            w_tgt = w_idx_oh;
        end
        w_ge = f_prefix(w_tgt);
    end

    // read the target slot
    always_comb begin
        w_rd_hdl = '0;
        w_rd_seq = '0;
        w_rd_byt = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rd_hdl = w_rd_hdl | (w_hdl[i] & {HW{w_tgt[i]}});
            w_rd_seq = w_rd_seq | (w_seq[i] & {(SEQ_BITS+1){w_tgt[i]}});
            w_rd_byt = w_rd_byt | (w_byt[i] & {BW{w_tgt[i]}});
        end
    end

    // next state and command execution
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_total  = r_total;
        n_served = r_served;
        n_dscan  = r_dscan;
        n_drem   = r_drem;
        n_dsum   = r_dsum;
        n_dcnt   = r_dcnt;
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        w_shk    = 1'b0;
        w_emit   = 1'b0;
        w_e_sts  = sopq_pkg::STS_OK;
        w_e_hdl  = '0;
        w_e_seq  = '0;
        w_e_byt  = '0;
        w_e_last = 1'b1;
        unique case (r_state)
            sopq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = sopq_pkg::S_EXEC;
                end
            end
            sopq_pkg::S_EXEC: begin
                if (r_cmd == sopq_pkg::CMD_DROP_TILL) begin
                    n_state = sopq_pkg::S_DSCAN;
                    n_dscan = w_fl;
                    n_drem  = w_fl;
                    n_dsum  = '0;
                    n_dcnt  = '0;
                end else if (w_ofree) begin
                    n_state = sopq_pkg::S_IDLE;
                    w_emit  = 1'b1;
                    case (r_cmd)
                        sopq_pkg::CMD_PUSH_BACK,
                        sopq_pkg::CMD_ORDERED: begin
                            if (w_full) begin
                                w_e_sts = sopq_pkg::STS_FULL;
                            end else begin
                                if (w_empty) n_served = r_now;
                                w_ins = 1'b1;
                            end
                        end
                        sopq_pkg::CMD_PUSH_FRONT_U: begin
                            if (w_found) begin
                                w_e_sts = sopq_pkg::STS_DUP;
                            end else if (w_full) begin
                                w_e_sts = sopq_pkg::STS_FULL;
                            end else begin
                                w_ins = 1'b1;
                            end
                        end
                        sopq_pkg::CMD_POP_FRONT,
                        sopq_pkg::CMD_POP_BACK,
                        sopq_pkg::CMD_REMOVE_SEQ,
                        sopq_pkg::CMD_POP_SENDABLE: begin
                            if (r_cmd == sopq_pkg::CMD_POP_FRONT) n_served = r_now;
                            if (w_empty || (w_use_search && !w_found)) begin
                                w_e_sts = sopq_pkg::STS_MISS;
                            end else begin
                                if (r_cmd == sopq_pkg::CMD_POP_BACK &&
                                    r_count == CNT_W'(1)) begin
                                    n_served = r_now;
                                end
                                w_rem = 1'b1;
                            end
                        end
                        sopq_pkg::CMD_PEEK_FRONT,
                        sopq_pkg::CMD_PEEK_BACK,
                        sopq_pkg::CMD_PEEK_SEQ,
                        sopq_pkg::CMD_SIZE_AT: begin
                            if (w_empty || (w_use_search && !w_found) ||
                                (r_cmd == sopq_pkg::CMD_SIZE_AT &&
                                 (r_pos == '0 || r_pos > r_count))) begin
                                w_e_sts = sopq_pkg::STS_MISS;
                            end else begin
                                w_e_hdl = w_rd_hdl;
                                w_e_seq = w_rd_seq;
                                w_e_byt = w_rd_byt;
                            end
                        end
                        sopq_pkg::CMD_SHRINK: begin
                            if (w_empty || w_rd_byt <= r_shr) begin
                                w_e_sts = sopq_pkg::STS_MISS;
                            end else begin
                                w_shk   = 1'b1;
                                w_e_hdl = w_rd_hdl;
                                w_e_seq = w_rd_seq;
                                w_e_byt = w_rd_byt;
                                n_total = r_total - TOT_W'(r_shr);
                            end
                        end
                        sopq_pkg::CMD_TOUCH: n_served = r_now;
                        default: ;
                    endcase
                    if (w_ins) begin
                        n_count = r_count + CNT_W'(1);
                        n_total = r_total + TOT_W'(r_byt);
                    end
                    if (w_rem) begin
                        n_count = r_count - CNT_W'(1);
                        n_total = r_total - TOT_W'(w_rd_byt);
                        w_e_hdl = w_rd_hdl;
                        w_e_seq = w_rd_seq;
                        w_e_byt = w_rd_byt;
                    end
                end
            end
            sopq_pkg::S_DSCAN: begin
                if (!w_found) begin
                    if (r_dcnt == '0) begin
                        if (w_ofree) begin
                            w_emit  = 1'b1;
                            w_e_sts = sopq_pkg::STS_MISS;
                            n_state = sopq_pkg::S_IDLE;
                        end
                    end else begin
                        n_total = r_total - r_dsum;
                        n_count = r_count - r_dcnt;
                        n_state = sopq_pkg::S_DREM;
                    end
                end else begin
                    n_dscan = r_dscan & ~w_sfirst;
                    n_dsum  = r_dsum + TOT_W'(w_rd_byt);
                    n_dcnt  = r_dcnt + CNT_W'(1);
                end
            end
            sopq_pkg::S_DREM: begin
                if (w_ofree) begin
                    w_emit   = 1'b1;
                    w_rem    = 1'b1;
                    w_e_hdl  = w_rd_hdl;
                    w_e_seq  = w_rd_seq;
                    w_e_byt  = w_rd_byt;
                    w_e_last = ((r_drem & ~w_sfirst) == '0);
                    n_drem   = ((r_drem >> 1) & w_ge) | (r_drem & ~w_ge);
                    if (w_e_last) n_state = sopq_pkg::S_IDLE;
                end
            end
            default: n_state = sopq_pkg::S_IDLE;
        endcase
    end

    // per-cell operation
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_op[i] = sopq_pkg::COP_HOLD;
            if (w_ins) begin
                if (w_tgt[i])     w_op[i] = sopq_pkg::COP_LOAD;
                else if (w_ge[i]) w_op[i] = sopq_pkg::COP_LEFT;
            end else if (w_rem) begin
                if (w_ge[i])      w_op[i] = sopq_pkg::COP_RIGHT;
            end else if (w_shk && i == 0) begin
                w_op[i] = sopq_pkg::COP_SHRINK;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sopq_pkg::S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_served    <= '0;
            r_dscan     <= '0;
            r_drem      <= '0;
            r_dsum      <= '0;
            r_dcnt      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_total  <= n_total;
            r_served <= n_served;
            r_dscan  <= n_dscan;
            r_drem   <= n_drem;
            r_dsum   <= n_dsum;
            r_dcnt   <= n_dcnt;
            if (w_emit)           o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
    end

    // captured word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= sopq_pkg::t_cmd'(i_cmd);
            r_key <= i_key_seq;
            r_hdl <= i_pkt_handle;
            r_byt <= i_pkt_bytes;
            r_pos <= i_position;
            r_shr <= i_shrink_bytes;
            r_now <= i_now_time;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_status       <= w_e_sts;
            o_out_handle   <= w_e_hdl;
            o_out_seq      <= w_e_seq;
            o_out_bytes    <= w_e_byt;
            o_total_bytes  <= n_total;
            o_queue_length <= n_count;
            o_served_time  <= n_served;
            o_last         <= w_e_last;
        end
    end

    `SOPQ_AST_IMP(a_cnt_max, 1'b1, r_count <= CNT_W'(DEPTH))
    `SOPQ_AST_NXT(a_acc_exec, w_accept, r_state == sopq_pkg::S_EXEC)
    `SOPQ_AST_IMP(a_drem_nz, r_state == sopq_pkg::S_DREM, r_drem != '0)
    `SOPQ_AST_IMP(a_dcnt_le, r_state == sopq_pkg::S_DSCAN, r_dcnt <= r_count)

endmodule
